// ----- src/sipq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted insertion priority queue package
// Shared sizes, codes and the per-cell control struct of the queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

  // Number of entries the queue holds.
  localparam int Depth = 16;
  // Width of the fill count, which must hold Depth itself.
  localparam int CntW = $clog2(Depth + 1);
  // Width of one stored value.
  localparam int ValW = 32;

  typedef enum logic {
    ActPush = 1'b0,
    ActPop  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StPopEmpty = 2'd1,
    StPushFull = 2'd2
  } status_e;

  // Operation broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

// ----- src/sipq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted insertion priority queue cell
// One slot of the queue: holds a value, ranks it against a new value and
// keeps it, takes the new value, or shifts with its neighbors.
// ----------------------------------------------------------------------------
module sipq_cell (
  input  logic                                 clk_i,
  input  logic                                 mode_i,
  input  logic                                 occ_i,
  input  sipq_pkg::cell_ctl_t                  ctl_i,
  input  logic signed [sipq_pkg::ValW-1:0]     new_value_i,
  input  logic signed [sipq_pkg::ValW-1:0]     from_above_i,
  input  logic signed [sipq_pkg::ValW-1:0]     from_below_i,
  input  logic                                 stay_i,
  output logic                                 stay_o,
  output logic signed [sipq_pkg::ValW-1:0]     value_o,
  output logic signed [sipq_pkg::ValW-1:0]     next_o
);

  logic signed [sipq_pkg::ValW-1:0] value_q, value_d;
  logic                             ranks_above;
  logic                             keep;

  // In max order a stored entry stays above a strictly smaller new value;
  // in min order above a strictly larger one.
  assign ranks_above = mode_i ? (value_q < new_value_i) : (value_q > new_value_i);

  // Every slot above this one kept its entry, and so does this one.
  assign keep   = stay_i & occ_i & ranks_above;
  assign stay_o = keep;

  always_comb begin
    value_d = value_q;
    if (ctl_i.push) begin
      if (keep) begin
        value_d = value_q;
      end else if (stay_i) begin
        value_d = new_value_i;
      end else begin
        value_d = from_above_i;
      end
    end else if (ctl_i.pop) begin
      value_d = from_below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign next_o  = value_d;

endmodule

// ----- src/sorted_insertion_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted insertion priority queue
// Bounded priority queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   An item is a push or a pop command. It is accepted at a rising clock edge
//   with start high and busy low. In the next cycle done_o is high for
//   one cycle and the result ports carry the popped value, the new top, the
//   empty flag, the fill count and a status code. The receiver cannot stall
//   the result; it must take it in that cycle.
//   Throughput is one item per cycle while busy is low: all cells compare
//   the new value against their entry in parallel, and a keep flag ripples
//   down the chain from the top cell, so each cell knows in the same cycle
//   whether to keep its entry, take the new value or shift down. A pop shifts
//   every cell up by one. The user must write the order_mode register (0
//   largest on top, 1 smallest on top) through the cfg channel only while no
//   item is in flight; the block does not enforce this. Changing it does not
//   reorder stored entries. Reset clears the fill count and the mode; stored
//   values are not cleared, since slots at or beyond the fill count are never
//   shown. busy is high for the first cycle after reset and low from then on.
// ----------------------------------------------------------------------------
module sorted_insertion_priority_queue (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 action_i,
  input  logic signed [sipq_pkg::ValW-1:0]     push_value_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 cfg_data_i,
  output logic                                 done_o,
  output logic signed [sipq_pkg::ValW-1:0]     popped_value_o,
  output logic                                 popped_valid_o,
  output logic signed [sipq_pkg::ValW-1:0]     top_value_o,
  output logic                                 is_empty_o,
  output logic [sipq_pkg::CntW-1:0]            fill_count_o,
  output logic [1:0]                           status_o
);

  localparam int Depth = sipq_pkg::Depth;
  localparam int CntW  = sipq_pkg::CntW;
  localparam int ValW  = sipq_pkg::ValW;

  logic                   busy_q;
  logic                   mode_q;
  logic [CntW-1:0]        count_q, count_d;
  logic                   done_q;
  logic signed [ValW-1:0] popped_value_q;
  logic                   popped_valid_q;
  logic signed [ValW-1:0] top_value_q, top_value_d;
  sipq_pkg::status_e      status_q, status_d;

  logic                   accept;
  logic                   is_pop;
  logic                   full;
  logic                   empty;
  sipq_pkg::cell_ctl_t    ctl;

  logic [Depth-1:0]       occ;
  logic [Depth:0]         stay;
  logic signed [ValW-1:0] cell_val  [Depth];
  logic signed [ValW-1:0] cell_next [Depth];

  assign accept = start & ~busy_q;
  assign is_pop = (action_i == sipq_pkg::ActPop);
  assign full   = (count_q == CntW'(Depth));
  assign empty  = (count_q == '0);

  assign ctl.push = accept & ~is_pop & ~full;
  assign ctl.pop  = accept & is_pop & ~empty;

  // The top cell always sees an unbroken run of kept entries above it.
  assign stay[0] = 1'b1;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic signed [ValW-1:0] from_above;
    logic signed [ValW-1:0] from_below;

    assign occ[k] = (count_q > CntW'(k));

    if (k == 0) begin : g_top
      assign from_above = push_value_i;
    end else begin : g_mid
      assign from_above = cell_val[k-1];
    end

    if (k == Depth - 1) begin : g_bottom
      assign from_below = cell_val[k];
    end else begin : g_inner
      assign from_below = cell_val[k+1];
    end

    sipq_cell u_cell (
      .clk_i        (clk_i),
      .mode_i       (mode_q),
      .occ_i        (occ[k]),
      .ctl_i        (ctl),
      .new_value_i  (push_value_i),
      .from_above_i (from_above),
      .from_below_i (from_below),
      .stay_i       (stay[k]),
      .stay_o       (stay[k+1]),
      .value_o      (cell_val[k]),
      .next_o       (cell_next[k])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctl.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctl.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    status_d = sipq_pkg::StOk;
    if (is_pop && empty) begin
      status_d = sipq_pkg::StPopEmpty;
    end else if (!is_pop && full) begin
      status_d = sipq_pkg::StPushFull;
    end
  end

  // The top after this item is whatever the top cell holds next.
  assign top_value_d = (count_d == '0) ? '0 : cell_next[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b1;
      mode_q   <= 1'b0;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= sipq_pkg::StOk;
    end else begin
      busy_q <= 1'b0;
      done_q <= accept;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      if (accept) begin
        count_q  <= count_d;
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_value_q <= ctl.pop ? cell_val[0] : '0;
      popped_valid_q <= ctl.pop;
      top_value_q    <= top_value_d;
    end
  end

  assign busy           = busy_q;
  assign cfg_ready_o    = ~busy_q;
  assign done_o         = done_q;
  assign popped_value_o = popped_value_q;
  assign popped_valid_o = popped_valid_q;
  assign top_value_o    = top_value_q;
  assign is_empty_o     = (count_q == '0);
  assign fill_count_o   = count_q;
  assign status_o       = status_q;

  // Every accepted item yields a result in the next cycle and no other.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted item gave no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without an accepted item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && popped_valid_o) |-> (status_o == sipq_pkg::StOk))
    else $error("pop reported with error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == sipq_pkg::StPushFull) |-> (fill_count_o == CntW'(Depth)))
    else $error("full push flagged while not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (top_value_o == '0))
    else $error("empty queue shows a nonzero top");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insertion priority queue testbench
// Sends push and pop commands to the queue in random bursts, keeps a sorted
// copy of the store to predict every result, and checks each result field by
// field. The order mode is changed between phases, sometimes while entries
// are stored.
// ----------------------------------------------------------------------------
module tb_top;

  // One command as it is presented to the queue.
  typedef struct {
    sipq_pkg::action_e                 action;
    logic signed [sipq_pkg::ValW-1:0]  value;
  } queue_cmd_t;

  // One result as the queue reports it.
  typedef struct {
    logic signed [sipq_pkg::ValW-1:0]  popped_value;
    logic                              popped_valid;
    logic signed [sipq_pkg::ValW-1:0]  top_value;
    logic                              is_empty;
    logic [sipq_pkg::CntW-1:0]         fill_count;
    sipq_pkg::status_e                 status;
  } queue_result_t;

  localparam logic signed [sipq_pkg::ValW-1:0] MaxVal = 32'sh7FFF_FFFF;
  localparam logic signed [sipq_pkg::ValW-1:0] MinVal = 32'sh8000_0000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              action_i = sipq_pkg::ActPush;
  logic signed [sipq_pkg::ValW-1:0]  push_value_i = '0;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic                              cfg_data_i = 1'b0;
  logic                              done_o;
  logic signed [sipq_pkg::ValW-1:0]  popped_value_o;
  logic                              popped_valid_o;
  logic signed [sipq_pkg::ValW-1:0]  top_value_o;
  logic                              is_empty_o;
  logic [sipq_pkg::CntW-1:0]         fill_count_o;
  logic [1:0]                        status_o;

  sorted_insertion_priority_queue i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .push_value_i   (push_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .popped_value_o (popped_value_o),
    .popped_valid_o (popped_valid_o),
    .top_value_o    (top_value_o),
    .is_empty_o     (is_empty_o),
    .fill_count_o   (fill_count_o),
    .status_o       (status_o)
  );

  // The queue as we expect it to be. Slot 0 is the bottom and slot
  // model_count-1 is the top.
  logic signed [sipq_pkg::ValW-1:0]  model_entries [sipq_pkg::Depth];
  int unsigned                       model_count = 0;
  logic                              model_mode = 1'b0;

  queue_cmd_t                        pending_cmds [$];
  queue_result_t                     expected_results [$];
  int unsigned                       mismatch_count = 0;

  // Sender pacing: a burst of back-to-back commands, then an idle gap.
  queue_cmd_t                        cur_cmd;
  int unsigned                       burst_left = 1;
  int unsigned                       gap_left = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Applies one accepted command to the model and returns what the queue
  // must report for it. A new value is inserted above every stored entry
  // that does not rank strictly above it, so equal values end up nearer the
  // top than the entries already stored. The scan runs down from the top
  // on the stored order as it stands, which matters after a mode change.
  function automatic queue_result_t apply_command(input queue_cmd_t cmd);
    queue_result_t res;
    int unsigned   slot;
    logic          above;

    res.popped_value = '0;
    res.popped_valid = 1'b0;
    res.status       = sipq_pkg::StOk;
    if (cmd.action == sipq_pkg::ActPush) begin
      if (model_count >= sipq_pkg::Depth) begin
        res.status = sipq_pkg::StPushFull;
      end else begin
        slot = model_count;
        while (slot > 0) begin
          above = model_mode ? (model_entries[slot-1] < cmd.value)
                             : (model_entries[slot-1] > cmd.value);
          if (!above) break;
          model_entries[slot] = model_entries[slot-1];
          slot--;
        end
        model_entries[slot] = cmd.value;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        res.status = sipq_pkg::StPopEmpty;
      end else begin
        model_count--;
        res.popped_value = model_entries[model_count];
        res.popped_valid = 1'b1;
      end
    end
    res.top_value  = (model_count > 0) ? model_entries[model_count-1] : '0;
    res.is_empty   = (model_count == 0);
    res.fill_count = model_count[sipq_pkg::CntW-1:0];
    return res;
  endfunction

  // Driver. A command counts as taken at the edge where start is high and
  // busy is low; its result is predicted right there. A new command is only
  // presented once the current one has gone in or none is on the port.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results = {expected_results, apply_command(cur_cmd)};
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          start        <= 1'b1;
          action_i     <= cur_cmd.action;
          push_value_i <= cur_cmd.value;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // Roughly one burst in four runs straight into the next one.
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [sipq_pkg::ValW-1:0] want,
                             input logic [sipq_pkg::ValW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor. Every result lives for exactly one cycle and is matched with
  // the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin : check_result
      queue_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no command outstanding, fill count %0d",
                 $time, fill_count_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("popped_value", want.popped_value, popped_value_o);
        check_field("popped_valid", sipq_pkg::ValW'(want.popped_valid),
                    sipq_pkg::ValW'(popped_valid_o));
        check_field("top_value", want.top_value, top_value_o);
        check_field("is_empty", sipq_pkg::ValW'(want.is_empty),
                    sipq_pkg::ValW'(is_empty_o));
        check_field("fill_count", sipq_pkg::ValW'(want.fill_count),
                    sipq_pkg::ValW'(fill_count_o));
        check_field("status", sipq_pkg::ValW'(want.status),
                    sipq_pkg::ValW'(status_o));
      end
    end
  end

  function automatic queue_cmd_t make_cmd(input sipq_pkg::action_e act,
                                          input logic signed [sipq_pkg::ValW-1:0] val);
    queue_cmd_t cmd;
    cmd.action = act;
    cmd.value  = val;
    return cmd;
  endfunction

  // Appends one command to the pending list.
  task automatic add_cmd(input queue_cmd_t cmd);
    pending_cmds = {pending_cmds, cmd};
  endtask

  // Picks a push value: the extremes now and then, a narrow band near zero
  // so that equal values meet often, and full random words otherwise.
  function automatic logic signed [sipq_pkg::ValW-1:0] pick_value();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: return MaxVal;
      1: return MinVal;
      2: return ($urandom_range(0, 1) != 0) ? 32'sd0 : -32'sd1;
      3, 4: return $signed($urandom_range(0, 8)) - 32'sd4;
      default: return $signed($urandom);
    endcase
  endfunction

  // Queues a phase of random commands. The push share steers the fill level
  // so that some phases run the store full and others drain it to empty.
  task automatic queue_random_phase(input int unsigned count,
                                    input int unsigned push_pct);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(1, 100) <= push_pct) begin
        add_cmd(make_cmd(sipq_pkg::ActPush, pick_value()));
      end else begin
        // The value is ignored on a pop but is still driven at random.
        add_cmd(make_cmd(sipq_pkg::ActPop, $signed($urandom)));
      end
    end
  endtask

  // Waits until every command has gone in and every result has come back,
  // then keeps clocking so that the queue is truly quiet.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Writes the order mode. The model follows at the handshake edge; nothing
  // is in flight at that point.
  task automatic write_mode(input logic mode);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    model_mode = mode;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned push_pcts [4] = '{70, 50, 30, 50};

    // Directed part in the reset mode (largest on top): pop on an empty
    // store, the extremes of the value range, equal values, a run up to a
    // full store with one push too many, and a few pops.
    add_cmd(make_cmd(sipq_pkg::ActPop, MaxVal));
    add_cmd(make_cmd(sipq_pkg::ActPush, MaxVal));
    add_cmd(make_cmd(sipq_pkg::ActPush, MinVal));
    add_cmd(make_cmd(sipq_pkg::ActPush, 32'sd0));
    add_cmd(make_cmd(sipq_pkg::ActPush, -32'sd1));
    add_cmd(make_cmd(sipq_pkg::ActPush, 32'sd1));
    add_cmd(make_cmd(sipq_pkg::ActPush, 32'sd1));
    for (int n = 0; n < 10; n++) begin
      add_cmd(make_cmd(sipq_pkg::ActPush, pick_value()));
    end
    add_cmd(make_cmd(sipq_pkg::ActPush, 32'sh5555_AAAA));
    for (int n = 0; n < 3; n++) begin
      add_cmd(make_cmd(sipq_pkg::ActPop, MinVal));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_quiet();

    // Random phases. The mode flips between phases while entries are still
    // stored, so later pushes meet a store sorted the other way round.
    for (int unsigned phase = 0; phase < 8; phase++) begin
      write_mode((phase % 2) == 0);
      @(negedge clk_i);
      queue_random_phase(210, push_pcts[phase % 4]);
      wait_quiet();
    end

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog in case the queue stops taking commands or stops answering.
  initial begin
    #400us;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
src/sipq_pkg.sv
src/sipq_cell.sv
src/sorted_insertion_priority_queue.sv
tb/sv/tb_top.sv
